// ===== rtl/core/mer_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; used by mer_mac and midpoint_ellipse_rasterizer.
package mer_pkg;

	// Fixed field widths of the register and result interfaces
	localparam int CFG_AXIS_W = 10;
	localparam int CENTER_W   = 11;
	localparam int COORD_W    = 12;

	// Register port geometry
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int CFG_IDX_W  = 2;

	// Register indexes (byte address / 4)
	localparam logic [CFG_IDX_W-1:0] REG_SEMI_A   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEMI_B   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

	// Accumulator operation applied to the previous product
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD4,
		ACC_SUB4
	} acc_op_t;

	// Sequencer command to the multiply-accumulate unit
	typedef struct packed {
		logic    issue;
		acc_op_t acc_op;
	} mac_ctrl_t;

endpackage

// ===== rtl/core/midpoint_ellipse_rasterizer.sv =====
`timescale 1ns / 1ps
// Top level of the midpoint ellipse rasterizer: register port, walk sequencer, result register.
// Depends on mer_pkg and mer_mac.
//
//   channel | direction | signals                                   | transfer
//   in      | to block  | in_valid, in_stall, restart               | in_valid & !in_stall
//   out     | from block| out_valid, out_stall, x_right .. no_point | out_valid & !out_stall
//   cfg     | to block  | psel, penable, pwrite, paddr, pwdata      | psel & penable & pwrite
//
// An advance item moves from idle to the step state; there the result register loads the current point
// and the step adder advances the walk. A step that crosses into region two then runs tx, bt, ty, at, ab2, fin.
// A restart item runs the multiplier steps a*a, b*b, a*a*b and init before its step, and the region-two
// sequence as well when the a*a*b product is zero (zero a or zero b).
// The shared multiplier sets this order; in_stall is high whenever the sequencer is busy.
// A step waits while the result register is full and stalled. arst_n clears all walk state.
module midpoint_ellipse_rasterizer #(
	parameter int AXIS_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 restart,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mer_pkg::COORD_W-1:0]   x_right,
	output logic signed [mer_pkg::COORD_W-1:0]   x_left,
	output logic signed [mer_pkg::COORD_W-1:0]   y_top,
	output logic signed [mer_pkg::COORD_W-1:0]   y_bottom,
	output logic                                 last_point,
	output logic                                 no_point,
	// register port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mer_pkg::APB_AW-1:0]           paddr,
	input  logic [mer_pkg::APB_DW-1:0]           pwdata,
	output logic [mer_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready
);

	localparam int A   = AXIS_BITS;
	localparam int QW  = 2 * A;        // squared semi-axis
	localparam int OW  = 2 * A + 3;    // multiplier operand
	localparam int PW  = 2 * OW;       // product
	localparam int SW  = 3 * A + 3;    // step terms fx, fy
	localparam int DW  = 4 * A + 8;    // decision variable
	localparam int CW  = mer_pkg::COORD_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AA,
		S_BB,
		S_AB,
		S_INIT,
		S_TX,
		S_BT,
		S_TY,
		S_AT,
		S_AB2,
		S_FIN,
		S_STEP
	} state_t;

	typedef enum logic [1:0] {
		PH_DONE,
		PH_R1,
		PH_R2
	} phase_t;

	// configuration
	logic [mer_pkg::CFG_AXIS_W-1:0]       semi_a_q;
	logic [mer_pkg::CFG_AXIS_W-1:0]       semi_b_q;
	logic signed [mer_pkg::CENTER_W-1:0]  center_x_q;
	logic signed [mer_pkg::CENTER_W-1:0]  center_y_q;

	// walk state
	state_t                state_q;
	phase_t                phase_q;
	logic                  emit_pending_q;
	logic [A-1:0]          x_q;
	logic [A-1:0]          y_q;
	logic signed [SW-1:0]  fx_q;
	logic signed [SW-1:0]  fy_q;
	logic signed [DW-1:0]  decision_q;
	logic [QW-1:0]         asq_q;
	logic [QW-1:0]         bsq_q;

	// result register
	logic                  out_valid_q;
	logic signed [CW-1:0]  x_right_q;
	logic signed [CW-1:0]  x_left_q;
	logic signed [CW-1:0]  y_top_q;
	logic signed [CW-1:0]  y_bottom_q;
	logic                  last_point_q;
	logic                  no_point_q;

	// multiplier interface
	mer_pkg::mac_ctrl_t    mac_ctrl;
	logic signed [OW-1:0]  mac_a;
	logic signed [OW-1:0]  mac_b;
	logic signed [PW-1:0]  mac_prod;
	logic signed [DW-1:0]  mac_acc;

	// step datapath
	logic [A-1:0]          a_w;
	logic [A-1:0]          b_w;
	logic signed [OW-1:0]  asq_o;
	logic signed [OW-1:0]  bsq_o;
	logic signed [OW-1:0]  prod_lo;
	logic signed [OW-1:0]  tx;
	logic signed [A+1:0]   ty;
	logic signed [SW-1:0]  asq2;
	logic signed [SW-1:0]  bsq2;
	logic signed [DW-1:0]  asq_d;
	logic signed [DW-1:0]  bsq_d;
	logic [A-1:0]          x_n;
	logic [A-1:0]          y_n;
	logic signed [SW-1:0]  fx_n;
	logic signed [SW-1:0]  fy_n;
	logic signed [DW-1:0]  d_n;
	logic                  walk_active;
	logic                  need_rc;
	logic                  last_n;
	logic                  slot_free;
	logic                  load_result;
	logic signed [CW-1:0]  cx;
	logic signed [CW-1:0]  cy;
	logic signed [CW-1:0]  px;
	logic signed [CW-1:0]  py;
	logic signed [DW-1:0]  init_d;
	logic                  cfg_wr;

	// ---------------------------------------------------------------- register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			semi_a_q   <= '0;
			semi_b_q   <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mer_pkg::REG_SEMI_A:   semi_a_q   <= pwdata[mer_pkg::CFG_AXIS_W-1:0];
				mer_pkg::REG_SEMI_B:   semi_b_q   <= pwdata[mer_pkg::CFG_AXIS_W-1:0];
				mer_pkg::REG_CENTER_X: center_x_q <= pwdata[mer_pkg::CENTER_W-1:0];
				mer_pkg::REG_CENTER_Y: center_y_q <= pwdata[mer_pkg::CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (paddr[3:2])
			mer_pkg::REG_SEMI_A:   prdata = mer_pkg::APB_DW'(semi_a_q);
			mer_pkg::REG_SEMI_B:   prdata = mer_pkg::APB_DW'(semi_b_q);
			mer_pkg::REG_CENTER_X: prdata = mer_pkg::APB_DW'(center_x_q);
			mer_pkg::REG_CENTER_Y: prdata = mer_pkg::APB_DW'(center_y_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- operands
	assign a_w     = A'(semi_a_q);
	assign b_w     = A'(semi_b_q);
	assign asq_o   = OW'(asq_q);
	assign bsq_o   = OW'(bsq_q);
	assign prod_lo = OW'(mac_prod);
	assign tx      = OW'({x_q, 1'b1});
	assign ty      = $signed({2'b00, y_q}) - (A+2)'(1);
	assign asq2    = SW'(asq_q) <<< 1;
	assign bsq2    = SW'(bsq_q) <<< 1;
	assign asq_d   = DW'(asq_q);
	assign bsq_d   = DW'(bsq_q);

	// Initial decision from the a*a*b product
	assign init_d = (bsq_d <<< 2) - (DW'(mac_prod) <<< 2) + asq_d;

	// Drive the shared multiplier from the sequencer state
	always_comb begin
		mac_ctrl.issue  = 1'b0;
		mac_ctrl.acc_op = mer_pkg::ACC_HOLD;
		mac_a           = '0;
		mac_b           = '0;
		unique case (state_q)
			S_AA: begin
				mac_ctrl.issue = 1'b1;
				mac_a          = OW'(a_w);
				mac_b          = OW'(a_w);
			end
			S_BB: begin
				mac_ctrl.issue = 1'b1;
				mac_a          = OW'(b_w);
				mac_b          = OW'(b_w);
			end
			S_AB: begin
				mac_ctrl.issue = 1'b1;
				mac_a          = asq_o;
				mac_b          = OW'(b_w);
			end
			S_TX: begin
				mac_ctrl.issue = 1'b1;
				mac_a          = tx;
				mac_b          = tx;
			end
			S_BT: begin
				mac_ctrl.issue = 1'b1;
				mac_a          = bsq_o;
				mac_b          = prod_lo;
			end
			S_TY: begin
				mac_ctrl.issue  = 1'b1;
				mac_ctrl.acc_op = mer_pkg::ACC_LOAD;
				mac_a           = OW'(ty);
				mac_b           = OW'(ty);
			end
			S_AT: begin
				mac_ctrl.issue = 1'b1;
				mac_a          = asq_o;
				mac_b          = prod_lo;
			end
			S_AB2: begin
				mac_ctrl.issue  = 1'b1;
				mac_ctrl.acc_op = mer_pkg::ACC_ADD4;
				mac_a           = asq_o;
				mac_b           = bsq_o;
			end
			S_FIN: begin
				mac_ctrl.acc_op = mer_pkg::ACC_SUB4;
			end
			default: ;
		endcase
	end

	mer_mac #(
		.OP_W  (OW),
		.ACC_W (DW)
	) u_mac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.op_a     (mac_a),
		.op_b     (mac_b),
		.prod     (mac_prod),
		.acc_next (mac_acc)
	);

	// ---------------------------------------------------------------- step adder
	// Advance one point in the current region
	always_comb begin
		x_n  = x_q;
		y_n  = y_q;
		fx_n = fx_q;
		fy_n = fy_q;
		d_n  = decision_q;
		if (phase_q == PH_R1) begin
			x_n  = x_q + A'(1);
			fx_n = fx_q + bsq2;
			if (decision_q[DW-1]) begin
				d_n = decision_q + ((bsq_d + DW'(fx_n)) <<< 2);
			end else begin
				y_n  = y_q - A'(1);
				fy_n = fy_q - asq2;
				d_n  = decision_q + ((bsq_d + DW'(fx_n) - DW'(fy_n)) <<< 2);
			end
		end else if (phase_q == PH_R2) begin
			y_n  = y_q - A'(1);
			fy_n = fy_q - asq2;
			if (!decision_q[DW-1]) begin
				d_n = decision_q + ((asq_d - DW'(fy_n)) <<< 2);
			end else begin
				x_n  = x_q + A'(1);
				fx_n = fx_q + bsq2;
				d_n  = decision_q + ((asq_d - DW'(fy_n) + DW'(fx_n)) <<< 2);
			end
		end
	end

	assign walk_active = (phase_q == PH_R1) || (phase_q == PH_R2);
	assign need_rc     = (phase_q == PH_R1) && !(fx_n < fy_n);
	assign last_n      = (need_rc || (phase_q == PH_R2)) && (y_n == '0);

	// Mirror the current point about the centre
	assign cx = CW'(center_x_q);
	assign cy = CW'(center_y_q);
	assign px = CW'(x_q);
	assign py = CW'(y_q);

	assign slot_free   = !out_valid_q || !out_stall;
	assign load_result = (state_q == S_STEP) && slot_free;
	assign in_stall    = (state_q != S_IDLE);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			phase_q        <= PH_DONE;
			emit_pending_q <= 1'b0;
			x_q            <= '0;
			y_q            <= '0;
			fx_q           <= '0;
			fy_q           <= '0;
			decision_q     <= '0;
			asq_q          <= '0;
			bsq_q          <= '0;
			out_valid_q    <= 1'b0;
			x_right_q      <= '0;
			x_left_q       <= '0;
			y_top_q        <= '0;
			y_bottom_q     <= '0;
			last_point_q   <= 1'b0;
			no_point_q     <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && !load_result) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= restart ? S_AA : S_STEP;
					end
				end
				S_AA: state_q <= S_BB;
				S_BB: begin
					asq_q   <= QW'(mac_prod);
					state_q <= S_AB;
				end
				S_AB: begin
					bsq_q   <= QW'(mac_prod);
					state_q <= S_INIT;
				end
				S_INIT: begin
					// load the start of region one
					x_q            <= '0;
					y_q            <= b_w;
					fx_q           <= '0;
					fy_q           <= SW'(mac_prod) <<< 1;
					decision_q     <= init_d;
					phase_q        <= PH_R1;
					emit_pending_q <= 1'b1;
					state_q        <= (mac_prod == '0) ? S_TX : S_STEP;
				end
				S_TX:  state_q <= S_BT;
				S_BT:  state_q <= S_TY;
				S_TY:  state_q <= S_AT;
				S_AT:  state_q <= S_AB2;
				S_AB2: state_q <= S_FIN;
				S_FIN: begin
					// enter region two, or finish if no row is left
					decision_q <= mac_acc;
					phase_q    <= (y_q == '0) ? PH_DONE : PH_R2;
					state_q    <= emit_pending_q ? S_STEP : S_IDLE;
				end
				S_STEP: begin
					if (slot_free) begin
						out_valid_q    <= 1'b1;
						emit_pending_q <= 1'b0;
						if (walk_active) begin
							x_right_q    <= cx + px;
							x_left_q     <= cx - px;
							y_top_q      <= cy + py;
							y_bottom_q   <= cy - py;
							last_point_q <= last_n;
							no_point_q   <= 1'b0;
							x_q          <= x_n;
							y_q          <= y_n;
							fx_q         <= fx_n;
							fy_q         <= fy_n;
							decision_q   <= d_n;
							if (need_rc) begin
								state_q <= S_TX;
							end else begin
								if ((phase_q == PH_R2) && (y_n == '0)) begin
									phase_q <= PH_DONE;
								end
								state_q <= S_IDLE;
							end
						end else begin
							x_right_q    <= '0;
							x_left_q     <= '0;
							y_top_q      <= '0;
							y_bottom_q   <= '0;
							last_point_q <= 1'b0;
							no_point_q   <= 1'b1;
							phase_q      <= PH_DONE;
							state_q      <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign x_right    = x_right_q;
	assign x_left     = x_left_q;
	assign y_top      = y_top_q;
	assign y_bottom   = y_bottom_q;
	assign last_point = last_point_q;
	assign no_point   = no_point_q;

	// ---------------------------------------------------------------- checks
	// At rest, region one always has its step terms ordered
	a_r1_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && (phase_q == PH_R1) |-> (fx_q < fy_q))
		else $error("region one at rest with fx not below fy");

	// At rest, region two always has a row left to plot
	a_r2_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && (phase_q == PH_R2) |-> (y_q != '0))
		else $error("region two at rest with y at zero");

	// A result appears only from the step state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_STEP))
		else $error("result loaded outside the step state");

	// An empty result never marks a last point
	a_nopt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && no_point_q |-> !last_point_q && (x_right_q == '0))
		else $error("empty result carries point data");

endmodule

// ===== rtl/core/mer_mac.sv =====
`timescale 1ns / 1ps
// Shared signed multiply-accumulate unit of the ellipse rasterizer.
// Depends on mer_pkg for the command struct and accumulator codes.
module mer_mac #(
	parameter int OP_W  = 23,
	parameter int ACC_W = 48
) (
	input  logic                    clk,
	input  mer_pkg::mac_ctrl_t      ctrl,
	input  logic signed [OP_W-1:0]  op_a,
	input  logic signed [OP_W-1:0]  op_b,
	output logic signed [2*OP_W-1:0] prod,
	output logic signed [ACC_W-1:0] acc_next
);

	localparam int PW = 2 * OP_W;

	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_x4;

	// Scale the held product by four for the decision terms
	assign prod_x4 = ACC_W'(prod_q) <<< 2;
	assign prod    = prod_q;

	// Fold the previous product into the accumulator
	always_comb begin
		unique case (ctrl.acc_op)
			mer_pkg::ACC_LOAD: acc_next = ACC_W'(prod_q);
			mer_pkg::ACC_ADD4: acc_next = acc_q + prod_x4;
			mer_pkg::ACC_SUB4: acc_next = acc_q - prod_x4;
			default:           acc_next = acc_q;
		endcase
	end

	// Register the product and the running sum
	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			prod_q <= op_a * op_b;
		end
		acc_q <= acc_next;
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_ellipse_rasterizer: directed and random walks checked
// point by point against an in-bench midpoint ellipse walk. Depends on mer_pkg and the RTL.
module testbench;

	localparam int TOTAL_ITEMS   = 430;
	localparam int LONG_HOLD     = 250;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum logic [1:0] {
		WALK_DONE = 2'd0,
		WALK_R1   = 2'd1,
		WALK_R2   = 2'd2
	} walk_phase_t;

	typedef struct {
		logic signed [mer_pkg::COORD_W-1:0] x_right;
		logic signed [mer_pkg::COORD_W-1:0] x_left;
		logic signed [mer_pkg::COORD_W-1:0] y_top;
		logic signed [mer_pkg::COORD_W-1:0] y_bottom;
		logic                               last_point;
		logic                               no_point;
	} ellipse_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [mer_pkg::COORD_W-1:0] x_right;
	logic signed [mer_pkg::COORD_W-1:0] x_left;
	logic signed [mer_pkg::COORD_W-1:0] y_top;
	logic signed [mer_pkg::COORD_W-1:0] y_bottom;
	logic last_point;
	logic no_point;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mer_pkg::APB_AW-1:0] paddr = '0;
	logic [mer_pkg::APB_DW-1:0] pwdata = '0;
	logic [mer_pkg::APB_DW-1:0] prdata;
	logic pready;

	// Register copies and walk state of the predictor
	logic [mer_pkg::CFG_AXIS_W-1:0]      cfg_a = '0;
	logic [mer_pkg::CFG_AXIS_W-1:0]      cfg_b = '0;
	logic signed [mer_pkg::CENTER_W-1:0] cfg_cx = '0;
	logic signed [mer_pkg::CENTER_W-1:0] cfg_cy = '0;
	longint walk_x = 0;
	longint walk_y = 0;
	longint walk_fx = 0;
	longint walk_fy = 0;
	longint walk_d = 0;
	longint a_sq = 0;
	longint b_sq = 0;
	walk_phase_t walk_phase = WALK_DONE;

	ellipse_point_t expected_points[$];
	bit pending_restarts[$];
	bit item_taken = 1'b0;

	int tx_idle_pct = 11;
	int rx_idle_pct = 62;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int items_queued = 0;
	int items_sent = 0;
	int points_seen = 0;
	int ends_seen = 0;
	int empties_seen = 0;
	int fails = 0;
	int cycle_count = 0;

	midpoint_ellipse_rasterizer #(.AXIS_BITS(10)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_right(x_right), .x_left(x_left), .y_top(y_top), .y_bottom(y_bottom),
		.last_point(last_point), .no_point(no_point),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Move into the region that holds the next point, or finish the walk
	function void enter_next_region();
		longint tx;
		longint ty;
		if (walk_phase == WALK_R1 && !(walk_fx < walk_fy)) begin
			tx = 2 * walk_x + 1;
			ty = walk_y - 1;
			walk_d = b_sq * tx * tx + 4 * a_sq * ty * ty - 4 * a_sq * b_sq;
			walk_phase = WALK_R2;
		end
		if (walk_phase == WALK_R2 && !(walk_y > 0))
			walk_phase = WALK_DONE;
	endfunction

	// Predict the point that one accepted item yields and queue it
	function void advance_walk(input bit restart_bit);
		ellipse_point_t pt;
		longint px;
		longint py;
		longint cxv;
		longint cyv;
		cxv = cfg_cx;
		cyv = cfg_cy;
		if (restart_bit) begin
			a_sq = longint'(cfg_a) * longint'(cfg_a);
			b_sq = longint'(cfg_b) * longint'(cfg_b);
			walk_x = 0;
			walk_y = cfg_b;
			walk_fx = 0;
			walk_fy = 2 * a_sq * walk_y;
			walk_d = 4 * b_sq - 4 * a_sq * walk_y + a_sq;
			walk_phase = WALK_R1;
			enter_next_region();
		end
		if (walk_phase != WALK_R1 && walk_phase != WALK_R2) begin
			walk_phase = WALK_DONE;
			pt.x_right = '0;
			pt.x_left = '0;
			pt.y_top = '0;
			pt.y_bottom = '0;
			pt.last_point = 1'b0;
			pt.no_point = 1'b1;
		end else begin
			px = walk_x;
			py = walk_y;
			if (walk_phase == WALK_R1) begin
				walk_x += 1;
				walk_fx += 2 * b_sq;
				if (walk_d < 0) begin
					walk_d += 4 * (b_sq + walk_fx);
				end else begin
					walk_y -= 1;
					walk_fy -= 2 * a_sq;
					walk_d += 4 * (b_sq + walk_fx - walk_fy);
				end
			end else begin
				walk_y -= 1;
				walk_fy -= 2 * a_sq;
				if (walk_d >= 0) begin
					walk_d += 4 * (a_sq - walk_fy);
				end else begin
					walk_x += 1;
					walk_fx += 2 * b_sq;
					walk_d += 4 * (a_sq - walk_fy + walk_fx);
				end
			end
			enter_next_region();
			pt.x_right = mer_pkg::COORD_W'(cxv + px);
			pt.x_left = mer_pkg::COORD_W'(cxv - px);
			pt.y_top = mer_pkg::COORD_W'(cyv + py);
			pt.y_bottom = mer_pkg::COORD_W'(cyv - py);
			pt.last_point = (walk_phase == WALK_DONE);
			pt.no_point = 1'b0;
		end
		expected_points.push_back(pt);
	endfunction

	// Record input acceptance and predict its point
	always @(posedge clk) begin
		item_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			advance_walk(restart);
			items_sent++;
		end
	end

	// Sender: hold a stalled item, otherwise offer the next one or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !item_taken) begin
			in_valid <= 1'b1;
		end else if (pending_restarts.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
			in_valid <= 1'b1;
			restart <= pending_restarts.pop_front();
		end else begin
			in_valid <= 1'b0;
			restart <= 1'($urandom_range(0, 1));
		end
	end

	// Receiver: long hold-offs on request, random stalls otherwise
	always @(negedge clk) begin
		if (holds_served < holds_asked) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		ellipse_point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				$error("result with no item waiting for it");
				fails++;
			end else begin
				want = expected_points.pop_front();
				check_field("x_right", want.x_right, x_right);
				check_field("x_left", want.x_left, x_left);
				check_field("y_top", want.y_top, y_top);
				check_field("y_bottom", want.y_bottom, y_bottom);
				check_field("last_point", want.last_point, last_point);
				check_field("no_point", want.no_point, no_point);
				points_seen++;
				if (want.last_point)
					ends_seen++;
				if (want.no_point)
					empties_seen++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[midpoint_ellipse_rasterizer] ERROR");
			$finish;
		end
	end

	function void store_register(input logic [mer_pkg::CFG_IDX_W-1:0] idx,
			input logic [mer_pkg::APB_DW-1:0] val);
		case (idx)
			mer_pkg::REG_SEMI_A:   cfg_a = val[mer_pkg::CFG_AXIS_W-1:0];
			mer_pkg::REG_SEMI_B:   cfg_b = val[mer_pkg::CFG_AXIS_W-1:0];
			mer_pkg::REG_CENTER_X: cfg_cx = val[mer_pkg::CENTER_W-1:0];
			mer_pkg::REG_CENTER_Y: cfg_cy = val[mer_pkg::CENTER_W-1:0];
			default: ;
		endcase
	endfunction

	// Setup and access cycle; the register takes the value at the access edge
	task automatic reg_write(input logic [mer_pkg::CFG_IDX_W-1:0] idx,
			input logic [mer_pkg::APB_DW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mer_pkg::APB_AW'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		store_register(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Fill the bits above the register field with noise
	function automatic logic [mer_pkg::APB_DW-1:0] with_stray_bits(input int v, input int w);
		logic [mer_pkg::APB_DW-1:0] field_mask;
		field_mask = (mer_pkg::APB_DW'(1) << w) - 1;
		return (mer_pkg::APB_DW'($urandom()) & ~field_mask) |
			(mer_pkg::APB_DW'(v) & field_mask);
	endfunction

	task automatic set_centre(input int cx, input int cy);
		reg_write(mer_pkg::REG_CENTER_X, with_stray_bits(cx, mer_pkg::CENTER_W));
		reg_write(mer_pkg::REG_CENTER_Y, with_stray_bits(cy, mer_pkg::CENTER_W));
	endtask

	task automatic set_geometry(input int a, input int b, input int cx, input int cy);
		reg_write(mer_pkg::REG_SEMI_A, with_stray_bits(a, mer_pkg::CFG_AXIS_W));
		reg_write(mer_pkg::REG_SEMI_B, with_stray_bits(b, mer_pkg::CFG_AXIS_W));
		set_centre(cx, cy);
	endtask

	task automatic queue_item(input bit r);
		pending_restarts.push_back(r);
		items_queued++;
	endtask

	task automatic queue_walk(input int advances);
		queue_item(1'b1);
		repeat (advances)
			queue_item(1'b0);
	endtask

	// Sender pauses until every predicted point has come back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_restarts.size() != 0 || in_valid || expected_points.size() != 0);
	endtask

	function automatic int pick_axis(input bit big);
		if (big)
			return $urandom_range(0, 1) ? 1023 : int'($urandom_range(0, 1023));
		return ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 12));
	endfunction

	function automatic int pick_centre();
		case ($urandom_range(0, 4))
			0: return -1024;
			1: return 1023;
			default: return int'($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	// Mostly whole walks with random lengths; a few cut short or noise
	task automatic queue_walks(input bit big, input int count);
		int span;
		repeat (count) begin
			span = int'(cfg_a) + int'(cfg_b);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 4))
					queue_item(1'($urandom_range(0, 1)));
			end else if (big || span > 24) begin
				queue_walk($urandom_range(5, 25));
			end else if ($urandom_range(0, 4) == 0) begin
				queue_walk($urandom_range(0, span));
			end else begin
				queue_walk(span + 1 + $urandom_range(0, 1));
			end
		end
	endtask

	initial begin
		bit big;
		bit stage_two_hold;
		int phase_no;
		stage_two_hold = 1'b0;
		phase_no = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Advance before any restart, then restart on the reset geometry (zero b)
		queue_item(1'b0);
		wait_drained();
		queue_walk(1);
		wait_drained();
		// Small whole walk with extreme centre, past its end
		set_geometry(3, 2, 1023, -1024);
		queue_walk(6);
		wait_drained();
		// Zero a: region two only
		set_geometry(0, 3, -1024, 1023);
		queue_walk(4);
		wait_drained();
		// Zero b: empty walk
		set_geometry(5, 0, 0, 0);
		queue_walk(0);
		wait_drained();
		// Largest axes; then new registers mid-walk: centre live, axes at next restart
		set_geometry(1023, 1023, 0, 0);
		queue_walk(3);
		wait_drained();
		set_geometry(2, 2, -5, 7);
		repeat (2)
			queue_item(1'b0);
		queue_walk(1);
		wait_drained();

		// Random phases under three idling profiles
		while (items_queued < TOTAL_ITEMS) begin
			phase_no++;
			if (items_queued < 175) begin
				tx_idle_pct = 11;
				rx_idle_pct = 62;
			end else if (items_queued < 325) begin
				tx_idle_pct = 62;
				rx_idle_pct = 11;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			big = ($urandom_range(0, 9) == 0);
			if (phase_no == 2 || (tx_idle_pct == 0 && !stage_two_hold)) begin
				stage_two_hold = (tx_idle_pct == 0);
				holds_asked++;
				big = 1'b1;
			end
			if ($urandom_range(0, 4) == 0) begin
				// Carry on the previous walk under a new centre
				set_centre(pick_centre(), pick_centre());
				repeat ($urandom_range(1, 6))
					queue_item(1'b0);
			end else begin
				set_geometry(pick_axis(big), pick_axis(big), pick_centre(), pick_centre());
			end
			queue_walks(big, $urandom_range(1, 4));
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_points.size() != 0) begin
			$error("%0d predicted points never arrived", expected_points.size());
			fails++;
		end
		$display("Covered %0d items over %0d random phases: %0d points checked,",
			items_sent, phase_no, points_seen);
		$display("%0d walk ends and %0d empty results, %0d long receiver hold-offs.",
			ends_seen, empties_seen, holds_served);
		if (fails == 0) begin
			$display("[midpoint_ellipse_rasterizer] OK");
		end else begin
			$display("[midpoint_ellipse_rasterizer] ERROR");
		end
		$finish;
	end

endmodule
